// ===== sv/int128_to_decimal_text_macros.svh =====
// Assertion macros shared by the checker of the decimal text converter.
`ifndef INT128_TO_DECIMAL_TEXT_MACROS_SVH
`define INT128_TO_DECIMAL_TEXT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define I2D_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define I2D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/i2d_pkg.sv =====
// Shared types and constants of the signed binary to decimal text converter.
package i2d_pkg;

    localparam int VALUE_BITS_DEF = 128;
    localparam int DIGITS_DEF     = 39;
    localparam int DIGIT_W        = 4;
    localparam int IN_W           = 128;
    localparam int CHAR_W         = 8;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

    typedef enum logic [1:0] {
        DAB_IDLE,
        DAB_RUN,
        DAB_DONE
    } dab_state_t;

    typedef enum logic [1:0] {
        EMT_IDLE,
        EMT_SKIP,
        EMT_SIGN,
        EMT_DIGIT
    } emit_state_t;

    // Handoff of a finished conversion from the converter to the emitter.
    typedef struct packed {
        logic valid;
        logic neg;
    } i2d_hand_t;

endpackage

// ===== sv/i2d_dabble.sv =====
// Bit-serial shift-and-add-3 converter from a signed binary value to packed BCD.
module i2d_dabble #(
    parameter int VALUE_BITS = i2d_pkg::VALUE_BITS_DEF,
    parameter int DIGITS     = i2d_pkg::DIGITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [63:0]                          value_upper,
    input  logic [63:0]                          value_lower,
    output i2d_pkg::i2d_hand_t                   hand,
    output logic [DIGITS*i2d_pkg::DIGIT_W-1:0]   bcd,
    input  logic                                 take
);
    import i2d_pkg::*;

    localparam int MAG_W = VALUE_BITS;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int BCD_W = DIGITS * DIGIT_W;
    localparam logic [DIGIT_W-1:0] ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] ADJ_ADD = 4'd3;

    dab_state_t         state_reg, state_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               neg_reg, neg_next;

    logic [IN_W-1:0]    word;
    logic               sign;
    logic [MAG_W-1:0]   mag_in;
    logic [BCD_W-1:0]   bcd_adj;
    logic               load;
    logic               step;
    logic               last_step;

    assign word   = {value_upper, value_lower};
    assign sign   = word[VALUE_BITS-1];
    assign mag_in = sign ? (~word[MAG_W-1:0] + MAG_W'(1)) : word[MAG_W-1:0];

    // Every digit of five or more gets three added before the doubling shift.
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= ADJ_MIN) begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + ADJ_ADD;
            end else begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign last_step = (cnt_reg == CNT_W'(1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            DAB_IDLE: begin
                if (in_valid) begin
                    state_next = DAB_RUN;
                end
            end
            DAB_RUN: begin
                if (last_step) begin
                    state_next = DAB_DONE;
                end
            end
            DAB_DONE: begin
                if (take) begin
                    state_next = DAB_IDLE;
                end
            end
            default: state_next = DAB_IDLE;
        endcase
    end

    always_comb begin
        in_ready   = 1'b0;
        step       = 1'b0;
        hand.valid = 1'b0;
        hand.neg   = neg_reg;
        case (state_reg)
            DAB_IDLE: in_ready   = 1'b1;
            DAB_RUN:  step       = 1'b1;
            DAB_DONE: hand.valid = 1'b1;
            default:  in_ready   = 1'b0;
        endcase
    end

    assign load     = in_valid && in_ready;
    assign bcd      = bcd_reg;

    always_comb begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        if (load) begin
            mag_next = mag_in;
            bcd_next = '0;
            cnt_next = CNT_W'(VALUE_BITS);
            neg_next = sign;
        end else if (step) begin
            mag_next = {mag_reg[MAG_W-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[MAG_W-1]};
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DAB_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

endmodule

// ===== sv/i2d_emit.sv =====
// Digit-serial text emitter: drops leading zeros, sends sign and ASCII digits.
module i2d_emit #(
    parameter int DIGITS = i2d_pkg::DIGITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  i2d_pkg::i2d_hand_t                   hand,
    input  logic [DIGITS*i2d_pkg::DIGIT_W-1:0]   bcd,
    output logic                                 take,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [i2d_pkg::CHAR_W-1:0]           out_char,
    output logic                                 out_last
);
    import i2d_pkg::*;

    localparam int BCD_W = DIGITS * DIGIT_W;
    localparam int LEFT_W = $clog2(DIGITS + 1);

    emit_state_t          state_reg, state_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [LEFT_W-1:0]    left_reg, left_next;
    logic                 neg_reg, neg_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    out_char_reg, out_char_next;
    logic                 out_last_reg, out_last_next;

    logic [DIGIT_W-1:0]   top_digit;
    logic                 top_zero;
    logic                 one_left;
    logic                 slot_free;
    logic                 shift;
    logic                 send;
    logic [CHAR_W-1:0]    send_char;
    logic                 send_last;

    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign top_zero  = (top_digit == '0);
    assign one_left  = (left_reg == LEFT_W'(1));
    assign slot_free = !out_valid_reg || out_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            EMT_IDLE: begin
                if (hand.valid) begin
                    state_next = EMT_SKIP;
                end
            end
            EMT_SKIP: begin
                if (!(top_zero && !one_left)) begin
                    state_next = neg_reg ? EMT_SIGN : EMT_DIGIT;
                end
            end
            EMT_SIGN: begin
                if (slot_free) begin
                    state_next = EMT_DIGIT;
                end
            end
            EMT_DIGIT: begin
                if (slot_free && one_left) begin
                    state_next = EMT_IDLE;
                end
            end
            default: state_next = EMT_IDLE;
        endcase
    end

    always_comb begin
        take      = 1'b0;
        shift     = 1'b0;
        send      = 1'b0;
        send_char = CH_MINUS;
        send_last = 1'b0;
        case (state_reg)
            EMT_IDLE: take = hand.valid;
            EMT_SKIP: shift = top_zero && !one_left;
            EMT_SIGN: send = slot_free;
            EMT_DIGIT: begin
                send      = slot_free;
                shift     = slot_free;
                send_char = CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
                send_last = one_left;
            end
            default: take = 1'b0;
        endcase
    end

    always_comb begin
        bcd_next       = bcd_reg;
        left_next      = left_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (take) begin
            bcd_next  = bcd;
            left_next = LEFT_W'(DIGITS);
            neg_next  = hand.neg;
        end else if (shift) begin
            bcd_next  = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            left_next = left_reg - LEFT_W'(1);
        end
        if (send) begin
            out_valid_next = 1'b1;
            out_char_next  = send_char;
            out_last_next  = send_last;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= EMT_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        bcd_reg      <= bcd_next;
        left_reg     <= left_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== sv/int128_to_decimal_text.sv =====
// Top level of the signed binary integer to decimal ASCII text converter.
// An accepted input goes through the converter's bit loop, the handoff to the emitter,
// the emitter's zero skip and the output register before the first character leaves.
// Characters leave at one beat per cycle while m_tready holds; leading zeros are dropped first.
// Emission overlaps the conversion of the next value.
// Reset (aresetn low, synchronous) idles both units and empties the output register.
module int128_to_decimal_text #(
    parameter int VALUE_BITS = i2d_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input value channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [i2d_pkg::IN_W-1:0]      s_tdata,   // [63:0] value_upper, [127:64] value_lower
    // Result character channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [i2d_pkg::CHAR_W-1:0]    m_tdata,   // [7:0] char_code
    output logic                          m_tlast    // last_char
);
    import i2d_pkg::*;

    // Decimal digits that any magnitude below 2^VALUE_BITS can need.
    localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W  = DIGITS * DIGIT_W;

    i2d_hand_t          hand;
    logic [BCD_W-1:0]   bcd;
    logic               take;

    // The converter reads the low VALUE_BITS bits as a signed value, negates a
    // negative one to a magnitude, and then shifts one binary bit per cycle into a
    // row of BCD digit cells that each add three when at five or more.
    i2d_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_dabble (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .value_upper (s_tdata[63:0]),
        .value_lower (s_tdata[127:64]),
        .hand        (hand),
        .bcd         (bcd),
        .take        (take)
    );

    // The emitter copies the finished digits, which frees the converter for
    // the next value, then shifts them out one digit per cycle while the sink
    // accepts: leading zeros are dropped (a lone zero stays), a minus sign goes
    // first for negative values, and every character passes through a registered
    // output stage; a stalled sink holds the emitter and, through it, the converter.
    i2d_emit #(
        .DIGITS (DIGITS)
    ) u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hand      (hand),
        .bcd       (bcd),
        .take      (take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// ===== sv/i2d_checker.sv =====
// Port-level checker of the decimal text stream, bound to the top level.
`include "int128_to_decimal_text_macros.svh"

module i2d_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [i2d_pkg::CHAR_W-1:0]    m_tdata,
    input logic                          m_tlast
);
    import i2d_pkg::*;

    logic first_reg, first_next;
    logic start_reg, start_next;
    logic beat;

    assign beat = m_tvalid && m_tready;

    // first: the next beat opens a text; start: the next beat is its first digit.
    always_comb begin
        first_next = first_reg;
        start_next = start_reg;
        if (beat) begin
            first_next = m_tlast;
            start_next = m_tlast || (m_tdata == CH_MINUS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
            start_reg <= 1'b1;
        end else begin
            first_reg <= first_next;
            start_reg <= start_next;
        end
    end

    `I2D_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled character changed")
    `I2D_ASSERT_NOW(a_legal_char, m_tvalid, m_tdata == CH_MINUS || (m_tdata >= CH_ZERO && m_tdata <= CH_NINE), "character is neither a digit nor a minus")
    `I2D_ASSERT_NOW(a_minus_first, m_tvalid && m_tdata == CH_MINUS, first_reg && !m_tlast, "minus sign out of place")
    `I2D_ASSERT_NOW(a_no_lead_zero, m_tvalid && start_reg && m_tdata == CH_ZERO, m_tlast, "leading zero in decimal text")

endmodule

bind int128_to_decimal_text i2d_checker u_i2d_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
